>>> hw/rtl/bgd_pkg.sv
// Shared constants, types and register codes for the button gesture decoder.
package bgd_pkg;

   localparam int unsigned HOLD_WIDTH      = 16;
   localparam int unsigned GAP_WIDTH       = 12;
   localparam int unsigned TAP_WIDTH       = 4;
   localparam int unsigned SLOT_MAX        = 7;
   localparam int unsigned COUNTS_WIDTH    = TAP_WIDTH * SLOT_MAX;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = COUNTS_WIDTH;

   localparam int unsigned ACTION_SLOTS_DEFAULT = 7;

   localparam logic [HOLD_WIDTH-1:0]   SHORT_PRESS_RESET   = 16'd1800;
   localparam logic [GAP_WIDTH-1:0]    TAP_GAP_RESET       = 12'd750;
   localparam logic [HOLD_WIDTH-1:0]   LONG_HOLD_RESET     = 16'd1900;
   localparam logic [HOLD_WIDTH-1:0]   SHUTDOWN_HOLD_RESET = 16'd2000;
   localparam logic [HOLD_WIDTH-1:0]   FACTORY_WIPE_RESET  = 16'd10000;
   localparam logic [COUNTS_WIDTH-1:0] TAP_COUNTS_RESET    = 28'h2187A51;
   localparam logic [SLOT_MAX-1:0]     ACTION_ENABLE_RESET = 7'h7F;

   localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;
   localparam logic [GAP_WIDTH-1:0]  GAP_MAX  = '1;
   localparam logic [TAP_WIDTH-1:0]  TAP_MAX  = '1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SHORT_PRESS   = 3'd0,
      CSR_TAP_GAP       = 3'd1,
      CSR_LONG_HOLD     = 3'd2,
      CSR_SHUTDOWN_HOLD = 3'd3,
      CSR_FACTORY_WIPE  = 3'd4,
      CSR_TAP_COUNTS    = 3'd5,
      CSR_ACTION_ENABLE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic                 taps_done;
      logic [TAP_WIDTH-1:0] tap_total;
      logic [SLOT_MAX-1:0]  action_hits;
      logic                 long_hold;
      logic                 shutdown_now;
      logic                 factory_wipe;
   } result_type;

endpackage

>>> hw/rtl/bgd_ifs.sv
// Valid/ready channel interfaces for the button gesture decoder.
interface bgd_req_if import bgd_pkg::*; ();
   logic valid;
   logic ready;
   logic pin_level;

   modport source (output valid, output pin_level, input ready);
   modport sink   (input valid, input pin_level, output ready);
endinterface

interface bgd_rsp_if import bgd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 taps_done;
   logic [TAP_WIDTH-1:0] tap_total;
   logic [SLOT_MAX-1:0]  action_hits;
   logic                 long_hold;
   logic                 shutdown_now;
   logic                 factory_wipe;

   modport source (output valid, output taps_done, output tap_total, output action_hits,
                   output long_hold, output shutdown_now, output factory_wipe,
                   input ready);
   modport sink   (input valid, input taps_done, input tap_total, input action_hits,
                   input long_hold, input shutdown_now, input factory_wipe,
                   output ready);
endinterface

interface bgd_csr_if import bgd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bgd_action_match.sv
// Tap count to action slot matcher.
module bgd_action_match
   import bgd_pkg::*;
#(
   parameter int unsigned ACTION_SLOTS = ACTION_SLOTS_DEFAULT
) (
   input  logic [TAP_WIDTH-1:0]    tap_total,
   input  logic [COUNTS_WIDTH-1:0] tap_counts,
   input  logic [SLOT_MAX-1:0]     slot_enable,
   output logic [SLOT_MAX-1:0]     action_hits
);

   always_comb begin
      action_hits = '0;
      for (int i = 0; i < ACTION_SLOTS; i++) begin
         action_hits[i] = slot_enable[i] && (tap_counts[TAP_WIDTH*i +: TAP_WIDTH] == tap_total);
      end
   end

endmodule

>>> hw/rtl/button_gesture_decoder.sv
// Button gesture decoder top level: tap sequences, long hold, shutdown, factory reset.
//
// Usage:
//   req_if  - one word per millisecond tick, carrying the sampled button level.
//   rsp_if  - one word per tick accepted: taps_done with tap_total and action_hits,
//             plus the long_hold, shutdown_now and factory_wipe pulses.
//   csr_if  - register writes by index (0 short press limit .. 6 action enable);
//             always ready, indexes past the list are dropped. Write only while idle.
// The result for a tick is registered and appears in the cycle after its word is accepted.
// Throughput: one tick per cycle when not stalled; all gesture state is updated by a
//   single level of compare and increment logic feeding the state and result registers.
// The result register doubles as the skid stage: a new tick is taken whenever the
//   register is empty or its word leaves in the same cycle.
// When the receiver stalls, the pending result holds and req_if.ready drops until
//   the result is taken; no tick is lost or duplicated.
// Reset (synchronous, active high) clears all gesture state, empties the result
//   register and loads the register defaults; no clearing pass is needed.
module button_gesture_decoder
   import bgd_pkg::*;
#(
   parameter int unsigned ACTION_SLOTS = ACTION_SLOTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   bgd_req_if.sink   req_if,
   bgd_rsp_if.source rsp_if,
   bgd_csr_if.sink   csr_if
);

   // configuration registers
   logic [HOLD_WIDTH-1:0]   short_press_ff;
   logic [GAP_WIDTH-1:0]    tap_gap_ff;
   logic [HOLD_WIDTH-1:0]   long_hold_ff;
   logic [HOLD_WIDTH-1:0]   shutdown_hold_ff;
   logic [HOLD_WIDTH-1:0]   factory_time_ff;
   logic [COUNTS_WIDTH-1:0] tap_counts_ff;
   logic [SLOT_MAX-1:0]     action_enable_ff;

   // gesture state
   logic                  last_level_ff,     last_level_in;
   logic                  press_seen_ff,     press_seen_in;
   logic [HOLD_WIDTH-1:0] hold_timer_ff,     hold_timer_in;
   logic [GAP_WIDTH-1:0]  gap_timer_ff,      gap_timer_in;
   logic                  gap_running_ff,    gap_running_in;
   logic [TAP_WIDTH-1:0]  tap_counter_ff,    tap_counter_in;
   logic                  long_fired_ff,     long_fired_in;
   logic                  shutdown_fired_ff, shutdown_fired_in;
   logic                  factory_fired_ff,  factory_fired_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff,    result_in;

   logic                 req_take;
   logic                 rising;
   logic                 falling;
   logic                 gap_restarted;
   logic                 shut_before;
   logic [TAP_WIDTH-1:0] done_total;
   logic [SLOT_MAX-1:0]  match_hits;

   // Take a tick whenever the result register is free or draining this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rising  = req_if.pin_level && !last_level_ff;
   assign falling = !req_if.pin_level && last_level_ff;

   bgd_action_match #(
      .ACTION_SLOTS (ACTION_SLOTS)
   ) u_match (
      .tap_total   (done_total),
      .tap_counts  (tap_counts_ff),
      .slot_enable (action_enable_ff),
      .action_hits (match_hits)
   );

   // Next gesture state and result for the tick on req_if.
   always_comb begin
      last_level_in     = req_if.pin_level;
      press_seen_in     = press_seen_ff;
      hold_timer_in     = hold_timer_ff;
      gap_timer_in      = gap_timer_ff;
      gap_running_in    = gap_running_ff;
      tap_counter_in    = tap_counter_ff;
      long_fired_in     = long_fired_ff;
      shutdown_fired_in = shutdown_fired_ff;
      factory_fired_in  = factory_fired_ff;
      gap_restarted     = 1'b0;
      done_total        = '0;
      result_in         = '0;

      // advance the hold timer while a press is in progress
      if (press_seen_ff && !rising && hold_timer_ff != HOLD_MAX) begin
         hold_timer_in = hold_timer_ff + 1'b1;
      end

      if (rising) begin
         press_seen_in     = 1'b1;
         hold_timer_in     = '0;
         gap_running_in    = 1'b0;
         long_fired_in     = 1'b0;
         shutdown_fired_in = 1'b0;
         factory_fired_in  = 1'b0;
      end else if (falling && press_seen_ff) begin
         press_seen_in = 1'b0;
         if (hold_timer_in < short_press_ff) begin
            // short release: count a tap and restart the gap timer
            if (tap_counter_ff != TAP_MAX) begin
               tap_counter_in = tap_counter_ff + 1'b1;
            end
            gap_timer_in   = '0;
            gap_running_in = 1'b1;
            gap_restarted  = 1'b1;
         end else begin
            // long release: drop the taps
            tap_counter_in = '0;
            gap_running_in = 1'b0;
         end
         hold_timer_in     = '0;
         long_fired_in     = 1'b0;
         shutdown_fired_in = 1'b0;
         factory_fired_in  = 1'b0;
      end

      // gap timeout closes the tap sequence
      if (gap_running_in && !gap_restarted) begin
         if (gap_timer_in != GAP_MAX) begin
            gap_timer_in = gap_timer_in + 1'b1;
         end
         if (gap_timer_in >= tap_gap_ff) begin
            result_in.taps_done = 1'b1;
            done_total          = tap_counter_in;
            tap_counter_in      = '0;
            gap_running_in      = 1'b0;
         end
      end
      result_in.tap_total   = done_total;
      result_in.action_hits = result_in.taps_done ? match_hits : '0;

      // hold events while the button stays down
      shut_before = shutdown_fired_in;
      if (req_if.pin_level && press_seen_in) begin
         if (!long_fired_in && hold_timer_in >= long_hold_ff) begin
            long_fired_in       = 1'b1;
            result_in.long_hold = 1'b1;
         end
         if (!shutdown_fired_in && hold_timer_in >= shutdown_hold_ff) begin
            shutdown_fired_in      = 1'b1;
            result_in.shutdown_now = 1'b1;
         end
         if (shut_before && !factory_fired_in && hold_timer_in > factory_time_ff) begin
            factory_fired_in       = 1'b1;
            result_in.factory_wipe = 1'b1;
         end
      end

      // hold the result until the receiver takes it
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff     <= 1'b0;
         press_seen_ff     <= 1'b0;
         hold_timer_ff     <= '0;
         gap_timer_ff      <= '0;
         gap_running_ff    <= 1'b0;
         tap_counter_ff    <= '0;
         long_fired_ff     <= 1'b0;
         shutdown_fired_ff <= 1'b0;
         factory_fired_ff  <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            last_level_ff     <= last_level_in;
            press_seen_ff     <= press_seen_in;
            hold_timer_ff     <= hold_timer_in;
            gap_timer_ff      <= gap_timer_in;
            gap_running_ff    <= gap_running_in;
            tap_counter_ff    <= tap_counter_in;
            long_fired_ff     <= long_fired_in;
            shutdown_fired_ff <= shutdown_fired_in;
            factory_fired_ff  <= factory_fired_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   // Register writes, truncated to each register's width.
   always_ff @(posedge clock) begin
      if (reset) begin
         short_press_ff   <= SHORT_PRESS_RESET;
         tap_gap_ff       <= TAP_GAP_RESET;
         long_hold_ff     <= LONG_HOLD_RESET;
         shutdown_hold_ff <= SHUTDOWN_HOLD_RESET;
         factory_time_ff  <= FACTORY_WIPE_RESET;
         tap_counts_ff    <= TAP_COUNTS_RESET;
         action_enable_ff <= ACTION_ENABLE_RESET;
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_SHORT_PRESS:   short_press_ff   <= csr_if.data[HOLD_WIDTH-1:0];
            CSR_TAP_GAP:       tap_gap_ff       <= csr_if.data[GAP_WIDTH-1:0];
            CSR_LONG_HOLD:     long_hold_ff     <= csr_if.data[HOLD_WIDTH-1:0];
            CSR_SHUTDOWN_HOLD: shutdown_hold_ff <= csr_if.data[HOLD_WIDTH-1:0];
            CSR_FACTORY_WIPE:  factory_time_ff  <= csr_if.data[HOLD_WIDTH-1:0];
            CSR_TAP_COUNTS:    tap_counts_ff    <= csr_if.data[COUNTS_WIDTH-1:0];
            CSR_ACTION_ENABLE: action_enable_ff <= csr_if.data[SLOT_MAX-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.taps_done    = result_ff.taps_done;
   assign rsp_if.tap_total    = result_ff.tap_total;
   assign rsp_if.action_hits  = result_ff.action_hits;
   assign rsp_if.long_hold    = result_ff.long_hold;
   assign rsp_if.shutdown_now = result_ff.shutdown_now;
   assign rsp_if.factory_wipe = result_ff.factory_wipe;

`ifndef SYNTH
   // A running gap timer always has at least one tap behind it.
   a_gap_has_taps: assert property (@(posedge clock) disable iff (reset)
      gap_running_ff |-> tap_counter_ff != '0)
      else $error("gap timer running with no taps");

   // The hold timer rests at zero between presses.
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !press_seen_ff |-> hold_timer_ff == '0)
      else $error("hold timer moved without a press");

   // Factory reset can only have fired after shutdown in the same hold.
   a_factory_after_shut: assert property (@(posedge clock) disable iff (reset)
      factory_fired_ff |-> shutdown_fired_ff)
      else $error("factory reset fired without shutdown");

   // Tap fields stay zero unless a sequence ended.
   a_idle_tap_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.taps_done |->
         result_ff.tap_total == '0 && result_ff.action_hits == '0)
      else $error("tap fields set without taps_done");

   // A tick is only taken when the result register can accept it.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !req_take)
      else $error("tick taken over a stalled result");
`endif

endmodule
